### rtl/jhdp_pkg.sv
// types and constants shared by the jpeg header dimension parser
package jhdp_pkg;

  // parse phases, one-hot
  typedef enum logic [19:0] {
    PH_IDLE    = 20'h00001,
    PH_SOI2    = 20'h00002,
    PH_SCAN    = 20'h00004,
    PH_GOTFF   = 20'h00008,
    PH_ALEN_HI = 20'h00010,
    PH_ALEN_LO = 20'h00020,
    PH_A_J     = 20'h00040,
    PH_A_F     = 20'h00080,
    PH_A_I     = 20'h00100,
    PH_A_F2    = 20'h00200,
    PH_A_Z     = 20'h00400,
    PH_A_SKIP  = 20'h00800,
    PH_SLEN_HI = 20'h01000,
    PH_SLEN_LO = 20'h02000,
    PH_S_PREC  = 20'h04000,
    PH_S_H_HI  = 20'h08000,
    PH_S_H_LO  = 20'h10000,
    PH_S_W_HI  = 20'h20000,
    PH_S_W_LO  = 20'h40000,
    PH_DONE    = 20'h80000
  } phase_t;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  // marker and identifier bytes
  localparam logic [7:0] MK_FF   = 8'hFF;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_APP0 = 8'hE0;
  localparam logic [7:0] MK_SOF0 = 8'hC0;
  localparam logic [7:0] MK_STUF = 8'h00;
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_NUL  = 8'h00;

  // segment length limits and app0 header bytes already consumed
  localparam logic [15:0] APP0_MIN_LEN = 16'd8;
  localparam logic [15:0] SOF0_MIN_LEN = 16'd11;
  localparam logic [15:0] APP0_HDR_CNT = 16'd7;

  // one result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] width;
    logic [15:0] height;
  } result_t;

endpackage

### rtl/jhdp_fsm.sv
// byte-wise marker scan state machine with segment counters
module jhdp_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic              last_byte,
  output logic              emit,
  output jhdp_pkg::result_t res
);
  import jhdp_pkg::*;

  phase_t      phase, phase_next, nxt;
  logic [15:0] seg_len, seg_len_next;
  logic [15:0] seg_cnt, seg_cnt_next;
  logic [15:0] hgt, hgt_next;
  logic [15:0] wid, wid_next;
  logic        err, tail;

  always_comb begin
    seg_len_next = seg_len;
    seg_cnt_next = seg_cnt;
    hgt_next     = hgt;
    wid_next     = wid;
    nxt          = phase;
    err          = 1'b0;
    tail         = 1'b1;
    emit         = 1'b0;
    res          = '0;
    if (first_byte) begin
      seg_len_next = '0;
      seg_cnt_next = '0;
      hgt_next     = '0;
      wid_next     = '0;
      if (data_byte == MK_FF) nxt = PH_SOI2;
      else err = 1'b1;
    end else begin
      unique case (phase)
        PH_SOI2: begin
          if (data_byte == MK_SOI) nxt = PH_SCAN;
          else err = 1'b1;
        end
        PH_SCAN: begin
          nxt = (data_byte == MK_FF) ? PH_GOTFF : PH_SCAN;
        end
        PH_GOTFF: begin
          priority if (data_byte == MK_FF) nxt = PH_GOTFF;
          else if (data_byte == MK_STUF) nxt = PH_SCAN;
          else if (data_byte == MK_APP0) nxt = PH_ALEN_HI;
          else if (data_byte == MK_SOF0) nxt = PH_SLEN_HI;
          else nxt = PH_SCAN;
        end
        PH_ALEN_HI: begin
          seg_len_next = {data_byte, 8'h00};
          nxt = PH_ALEN_LO;
        end
        PH_SLEN_HI: begin
          seg_len_next = {data_byte, 8'h00};
          nxt = PH_SLEN_LO;
        end
        PH_ALEN_LO: begin
          seg_len_next = {seg_len[15:8], data_byte};
          if (seg_len_next < APP0_MIN_LEN) err = 1'b1;
          else nxt = PH_A_J;
        end
        PH_A_J: begin
          if (data_byte == CH_J) nxt = PH_A_F;
          else err = 1'b1;
        end
        PH_A_F: begin
          if (data_byte == CH_F) nxt = PH_A_I;
          else err = 1'b1;
        end
        PH_A_I: begin
          if (data_byte == CH_I) nxt = PH_A_F2;
          else err = 1'b1;
        end
        PH_A_F2: begin
          if (data_byte == CH_F) nxt = PH_A_Z;
          else err = 1'b1;
        end
        PH_A_Z: begin
          seg_cnt_next = APP0_HDR_CNT;
          if (data_byte == CH_NUL) nxt = PH_A_SKIP;
          else err = 1'b1;
        end
        PH_A_SKIP: begin
          seg_cnt_next = seg_cnt + 16'd1;
          nxt = (seg_cnt_next >= seg_len) ? PH_SCAN : PH_A_SKIP;
        end
        PH_SLEN_LO: begin
          seg_len_next = {seg_len[15:8], data_byte};
          if (seg_len_next < SOF0_MIN_LEN) err = 1'b1;
          else nxt = PH_S_PREC;
        end
        PH_S_PREC: begin
          nxt = PH_S_H_HI;
        end
        PH_S_H_HI: begin
          hgt_next = {data_byte, 8'h00};
          nxt = PH_S_H_LO;
        end
        PH_S_H_LO: begin
          hgt_next = {hgt[15:8], data_byte};
          nxt = PH_S_W_HI;
        end
        PH_S_W_HI: begin
          wid_next = {data_byte, 8'h00};
          nxt = PH_S_W_LO;
        end
        PH_S_W_LO: begin
          wid_next   = {wid[15:8], data_byte};
          tail       = 1'b0;
          emit       = 1'b1;
          res.status = (wid_next == 16'd0 || hgt == 16'd0) ? ST_ZERO : ST_OK;
          res.width  = wid_next;
          res.height = hgt;
          nxt        = PH_DONE;
        end
        default: begin
          // idle or done: byte ignored
          tail = 1'b0;
        end
      endcase
    end
    // error wins over end of buffer
    if (tail) begin
      if (err) begin
        emit       = 1'b1;
        res.status = ST_ERR;
        nxt        = PH_DONE;
      end else if (last_byte) begin
        emit       = 1'b1;
        res.status = ST_END;
        nxt        = PH_DONE;
      end
    end
    phase_next = nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      seg_len <= '0;
      seg_cnt <= '0;
      hgt     <= '0;
      wid     <= '0;
    end else if (step) begin
      phase   <= phase_next;
      seg_len <= seg_len_next;
      seg_cnt <= seg_cnt_next;
      hgt     <= hgt_next;
      wid     <= wid_next;
    end
  end

endmodule

### rtl/jpeg_header_dimension_parser.sv
// top level of the jpeg header dimension parser with result skid stage
//
// channel  direction  handshake                  payload
// data     in         data_valid / data_ready    data_byte, first_byte, last_byte
// result   out        result_valid / result_ready status, image_width, image_height
//
// one byte per cycle while the skid slot is empty; the phase and segment registers close the loops
// with the output register free, a result appears there the cycle after its byte
// synchronous active-high reset returns to idle, waiting for a first byte
// a stalled result is held while later bytes keep flowing; a second result
// goes to a skid register, and only then does data_ready drop
module jpeg_header_dimension_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [15:0] image_width,
  output logic [15:0] image_height
);
  import jhdp_pkg::*;

  logic    accept;
  logic    emit;
  result_t res;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;
  logic    out_free;

  // input beat taken whenever the skid slot is empty
  assign data_ready = !skid_valid;
  assign accept     = data_valid && data_ready;
  assign out_free   = !result_valid || result_ready;

  jhdp_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .emit       (emit),
    .res        (res)
  );

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        // skid drains first; no input was taken this cycle
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept && emit;
      end
    end else if (accept && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) out_res <= skid_res;
      else out_res <= res;
    end
    if (!out_free && accept && emit) skid_res <= res;
  end

  assign status       = out_res.status;
  assign image_width  = out_res.width;
  assign image_height = out_res.height;

  // skid only fills behind a held output
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a result while output is empty");

  // after a produced result, the output is valid the next cycle
  a_emit_visible : assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> result_valid)
    else $error("result lost after emit");

  // ok never carries a zero dimension
  a_ok_nonzero : assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_OK) |-> (image_width != 16'd0 && image_height != 16'd0))
    else $error("ok status with zero dimension");

  // error and end results carry zero fields
  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == ST_ERR || status == ST_END))
      |-> (image_width == 16'd0 && image_height == 16'd0))
    else $error("failure result with nonzero dimensions");

endmodule
